// ===== rtl/lpd_pkg.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// Line position PID drive package
// Shared types, constants and command/status structures.
// -----------------------------------------------------------------------------
package lpd_pkg;

   localparam int SampleWidth = 12;
   localparam int DutyWidth   = 15;
   localparam int ErrWidth    = 14;
   localparam int CsrAddrWidth = 3;
   localparam int CsrDataWidth = 12;

   localparam logic [11:0] InLow   = 12'd1700;
   localparam int          InSpan  = 2300;
   localparam logic [9:0]  OutFull = 10'd1000;
   localparam logic signed [15:0] IntegralLimit = 16'sd7680;
   localparam logic signed [13:0] LostError     = 14'sd6400;

   localparam logic [CsrAddrWidth-1:0] RegGainP    = 3'd0;
   localparam logic [CsrAddrWidth-1:0] RegGainI    = 3'd1;
   localparam logic [CsrAddrWidth-1:0] RegGainD    = 3'd2;
   localparam logic [CsrAddrWidth-1:0] RegDarkThr  = 3'd3;
   localparam logic [CsrAddrWidth-1:0] RegBaseDuty = 3'd4;
   localparam logic [CsrAddrWidth-1:0] RegFloor    = 3'd5;
   localparam logic [CsrAddrWidth-1:0] RegCeiling  = 3'd6;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCALE, ST_SUM, ST_DIV, ST_ERR, ST_MUL, ST_DRIVE, ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic scale;
      logic sum;
      logic div_start;
      logic div_step;
      logic err;
      logic mul;
      logic drive;
   } cmd_type;

   typedef struct packed {
      logic div_last;
   } status_type;

   // Scales a raw sample to 0..1000, that is floor(d*10/23), by multiplying
   // d*10 by floor(2^16/23) = 2849 and then correcting the estimate upwards
   // by one where the remainder shows it fell short.
   function automatic logic [9:0] scale_sample(input logic [11:0] raw);
      logic [11:0] d;
      logic [14:0] n;
      logic [26:0] prod;
      logic [10:0] q;
      logic [14:0] rem;
      logic [9:0]  v;
      d = raw - InLow;
      n = 15'(d) * 15'd10;
      v = 10'd0;
      if (raw > InLow) begin
         prod = 27'(n) * 27'd2849;
         q = prod[26:16];
         rem = n - 15'(q) * 15'd23;
         if (rem >= 15'd23) begin
            q = q + 11'd1;
         end
         v = (q > 11'(OutFull)) ? OutFull : q[9:0];
      end
      return v;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/lpd_if.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// Line position PID drive channel interfaces
// Valid/ready channels for requests, results and register writes.
// -----------------------------------------------------------------------------
interface lpd_req_if;
   logic        valid;
   logic        ready;
   logic [11:0] sample_a;
   logic [11:0] sample_b;
   logic [11:0] sample_c;
   logic [11:0] sample_d;
   modport source (output valid, sample_a, sample_b, sample_c, sample_d, input ready);
   modport sink (input valid, sample_a, sample_b, sample_c, sample_d, output ready);
endinterface

interface lpd_rsp_if;
   logic               valid;
   logic               ready;
   logic        [14:0] left_duty;
   logic        [14:0] right_duty;
   logic signed [13:0] line_error;
   modport source (output valid, left_duty, right_duty, line_error, input ready);
   modport sink (input valid, left_duty, right_duty, line_error, output ready);
endinterface

interface lpd_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [11:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/line_position_pid_drive_unit.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// Line position PID drive unit
// Four reflectance samples in, left and right motor duty and line error out.
// -----------------------------------------------------------------------------
// Each request passes through the scale, sum, divide, error, multiply and drive steps
// before the result is offered; the 24-step restoring divider forms the centroid. One
// request is worked on at a time; the next is taken as the result is taken.
module line_position_pid_drive_unit (
   input wire logic clock,
   input wire logic reset,
   lpd_req_if.sink  req,
   lpd_rsp_if.source rsp,
   lpd_csr_if.sink  csr
);
   import lpd_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr.ready = 1'b1;

   lpd_ctrl u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .cmd, .status
   );

   lpd_datapath u_dp (
      .clock, .reset, .cmd, .status,
      .sample_a(req.sample_a), .sample_b(req.sample_b),
      .sample_c(req.sample_c), .sample_d(req.sample_d),
      .csr_we(csr.valid), .csr_index(csr.index), .csr_data(csr.data),
      .left_duty(rsp.left_duty), .right_duty(rsp.right_duty),
      .line_error(rsp.line_error)
   );
endmodule
`default_nettype wire

// ===== rtl/lpd_ctrl.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// Line position PID drive controller
// Sequences one request through the datapath and owns the handshakes.
// -----------------------------------------------------------------------------
module lpd_ctrl (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   output lpd_pkg::cmd_type    cmd,
   input  wire lpd_pkg::status_type status
);
   import lpd_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum       = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_ERR;
            end
         end
         ST_ERR: begin
            cmd.err  = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DRIVE;
         end
         ST_DRIVE: begin
            cmd.drive = 1'b1;
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            req_ready = rsp_ready;
            if (rsp_ready) begin
               if (req_valid) begin
                  cmd.load = 1'b1;
                  state_in = ST_SCALE;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      cmd.div_start = cmd.sum;
   end
endmodule
`default_nettype wire

// ===== rtl/lpd_datapath.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// Line position PID drive datapath
// Scaling, centroid sums, serial divider, PID terms and duty saturation.
// -----------------------------------------------------------------------------
module lpd_datapath (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire lpd_pkg::cmd_type    cmd,
   output lpd_pkg::status_type      status,
   input  wire logic [11:0]         sample_a,
   input  wire logic [11:0]         sample_b,
   input  wire logic [11:0]         sample_c,
   input  wire logic [11:0]         sample_d,
   input  wire logic                csr_we,
   input  wire logic [2:0]          csr_index,
   input  wire logic [11:0]         csr_data,
   output logic [14:0]              left_duty,
   output logic [14:0]              right_duty,
   output logic signed [13:0]       line_error
);
   import lpd_pkg::*;

   logic [11:0] gain_p_ff, gain_i_ff, gain_d_ff;
   logic [9:0]  dark_ff;
   logic [6:0]  base_ff, floor_ff, ceil_ff;
   logic [11:0] raw_ff [4];
   logic [9:0]  sc_ff [4];
   logic        seen_ff;
   logic [11:0] sum_ff;
   logic        neg_ff;
   logic [23:0] quo_ff;
   logic [23:0] rem_ff;
   logic [4:0]  cnt_ff;
   logic signed [15:0] last_ff, integ_ff;
   logic signed [13:0] err_ff;
   logic signed [15:0] diff_ff;
   logic signed [41:0] corr_ff;
   logic [14:0] left_ff, right_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff <= 12'd256;
         gain_i_ff <= 12'd0;
         gain_d_ff <= 12'd384;
         dark_ff   <= 10'd400;
         base_ff   <= 7'd80;
         floor_ff  <= 7'd65;
         ceil_ff   <= 7'd95;
      end else if (csr_we) begin
         unique case (csr_index)
            RegGainP:    gain_p_ff <= csr_data;
            RegGainI:    gain_i_ff <= csr_data;
            RegGainD:    gain_d_ff <= csr_data;
            RegDarkThr:  dark_ff   <= csr_data[9:0];
            RegBaseDuty: base_ff   <= csr_data[6:0];
            RegFloor:    floor_ff  <= csr_data[6:0];
            RegCeiling:  ceil_ff   <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   // Weighted sum magnitude, up to 4000.
   logic signed [14:0] wsum;
   logic [14:0]        wmag;
   logic [24:0]        trial;
   logic [24:0]        dividend;
   logic signed [14:0] qs;
   logic signed [13:0] err_new;
   logic signed [16:0] integ_sum;
   logic signed [15:0] integ_new;
   logic signed [42:0] lv, rv, lo, hi;

   always_comb begin
      wsum = 15'sd3 * $signed({5'd0, sc_ff[0]}) + $signed({5'd0, sc_ff[1]})
           - $signed({5'd0, sc_ff[2]}) - 15'sd3 * $signed({5'd0, sc_ff[3]});
      wmag = wsum[14] ? 15'(-wsum) : wsum;
      dividend = 25'(wmag) * 25'd2560;
      trial = {rem_ff, quo_ff[23]} - {13'd0, sum_ff};
      qs = neg_ff ? -$signed(quo_ff[14:0]) : $signed(quo_ff[14:0]);
      if (!seen_ff) begin
         err_new = (last_ff > 16'sd0) ? LostError : -LostError;
      end else if (sum_ff == 12'd0) begin
         err_new = 14'sd0;
      end else begin
         err_new = qs[13:0];
      end
      integ_sum = 17'(integ_ff) + 17'(err_new);
      if (integ_sum > 17'(IntegralLimit)) begin
         integ_new = IntegralLimit;
      end else if (integ_sum < -17'(IntegralLimit)) begin
         integ_new = -IntegralLimit;
      end else begin
         integ_new = integ_sum[15:0];
      end
      lv = {1'b0, base_ff, 16'd0} - 43'(corr_ff);
      rv = {1'b0, base_ff, 16'd0} + 43'(corr_ff);
      lo = {20'd0, floor_ff, 16'd0};
      hi = {20'd0, ceil_ff, 16'd0};
   end

   function automatic logic [14:0] sat(input logic signed [42:0] v,
                                      input logic signed [42:0] l,
                                      input logic signed [42:0] h);
      logic signed [42:0] c;
      c = v;
      if (v < l) begin
         c = l;
      end else if (v > h) begin
         c = h;
      end
      return c[22:8];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff  <= '0;
         integ_ff <= '0;
      end else if (cmd.err) begin
         last_ff  <= 16'(err_new);
         integ_ff <= integ_new;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         raw_ff[0] <= sample_a;
         raw_ff[1] <= sample_b;
         raw_ff[2] <= sample_c;
         raw_ff[3] <= sample_d;
      end
      if (cmd.scale) begin
         for (int i = 0; i < 4; i++) begin
            sc_ff[i] <= scale_sample(raw_ff[i]);
         end
      end
      if (cmd.sum) begin
         seen_ff <= (sc_ff[0] > dark_ff) || (sc_ff[1] > dark_ff)
                 || (sc_ff[2] > dark_ff) || (sc_ff[3] > dark_ff);
         sum_ff  <= 12'(sc_ff[0]) + 12'(sc_ff[1]) + 12'(sc_ff[2]) + 12'(sc_ff[3]);
         neg_ff  <= wsum[14];
         quo_ff  <= dividend[23:0];
         rem_ff  <= '0;
         cnt_ff  <= '0;
      end
      if (cmd.div_step) begin
         if (!trial[24]) begin
            rem_ff <= trial[23:0];
            quo_ff <= {quo_ff[22:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[22:0], quo_ff[23]};
            quo_ff <= {quo_ff[22:0], 1'b0};
         end
         cnt_ff <= cnt_ff + 5'd1;
      end
      if (cmd.err) begin
         err_ff  <= err_new;
         diff_ff <= 16'(err_new) - last_ff;
      end
      if (cmd.mul) begin
         corr_ff <= 42'($signed({1'b0, gain_p_ff}) * 42'(err_ff))
                  + 42'($signed({1'b0, gain_i_ff}) * 42'(integ_ff))
                  + 42'($signed({1'b0, gain_d_ff}) * 42'(diff_ff));
      end
      if (cmd.drive) begin
         left_ff  <= sat(lv, lo, hi);
         right_ff <= sat(rv, lo, hi);
      end
   end

   assign status.div_last = (cnt_ff == 5'd23);
   assign left_duty  = left_ff;
   assign right_duty = right_ff;
   assign line_error = err_ff;
endmodule
`default_nettype wire

// ===== rtl/lpd_checker.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// Line position PID drive checker
// Port-level properties of the request and result channels.
// -----------------------------------------------------------------------------
module lpd_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [14:0] left_duty
);
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !rsp_valid) else $error("early result");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(left_duty)))
      else $error("result dropped");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready) else $error("taken while stalled");
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> left_duty <= 15'd32512) else $error("duty out of range");
endmodule

bind line_position_pid_drive_unit lpd_checker u_lpd_checker (
   .clock, .reset,
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .left_duty(rsp.left_duty)
);
`default_nettype wire

// ===== test/line_position_pid_drive_unit_tb.sv =====
// -----------------------------------------------------------------------------
// Line position PID drive unit testbench
// Drives sensor sets and register writes with random gaps and stalls, predicts
// each duty pair and line error in a scoreboard and compares them in order.
// -----------------------------------------------------------------------------
module line_position_pid_drive_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lpd_pkg::*;

   typedef struct packed {
      logic [14:0] left_duty;
      logic [14:0] right_duty;
      logic signed [13:0] line_error;
   } drive_result_type;

   class drive_scoreboard;
      logic [11:0] kp, ki, kd;
      logic [9:0] dark;
      logic [6:0] base, floor_pct, ceil_pct;
      int prev_err, integral;
      drive_result_type pending[$];
      int mismatches, checked;

      function void reset_state();
         kp = 256; ki = 0; kd = 384; dark = 400;
         base = 80; floor_pct = 65; ceil_pct = 95;
         prev_err = 0; integral = 0;
         mismatches = 0; checked = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [11:0] value);
         case (idx)
            RegGainP:    kp = value;
            RegGainI:    ki = value;
            RegGainD:    kd = value;
            RegDarkThr:  dark = value[9:0];
            RegBaseDuty: base = value[6:0];
            RegFloor:    floor_pct = value[6:0];
            RegCeiling:  ceil_pct = value[6:0];
            default: ;
         endcase
      endfunction

      function int scaled(logic [11:0] raw);
         int v;
         if (raw <= 1700) return 0;
         v = (int'(raw) - 1700) * 1000 / 2300;
         return (v > 1000) ? 1000 : v;
      endfunction

      function logic [14:0] clamp_duty(longint q16);
         longint lo, hi;
         lo = longint'(floor_pct) * 65536;
         hi = longint'(ceil_pct) * 65536;
         if (q16 < lo) q16 = lo;
         else if (q16 > hi) q16 = hi;
         return q16[22:8];
      endfunction

      function void note_request(logic [11:0] s[4]);
         int wts[4] = '{3, 1, -1, -3};
         int wsum, total, s_v, err, diff;
         bit seen;
         longint corr, b;
         drive_result_type r;
         wsum = 0; total = 0; seen = 0;
         for (int i = 0; i < 4; i++) begin
            s_v = scaled(s[i]);
            if (s_v > int'(dark)) seen = 1;
            wsum += s_v * wts[i];
            total += s_v;
         end
         if (!seen) err = (prev_err > 0) ? 6400 : -6400;
         else if (total != 0) err = (wsum * 2560) / total;
         else err = 0;
         diff = err - prev_err;
         integral += err;
         if (integral > 7680) integral = 7680;
         else if (integral < -7680) integral = -7680;
         corr = longint'(kp) * err + longint'(ki) * integral + longint'(kd) * diff;
         prev_err = err;
         b = longint'(base) * 65536;
         r.left_duty = clamp_duty(b - corr);
         r.right_duty = clamp_duty(b + corr);
         r.line_error = err[13:0];
         pending.push_back(r);
      endfunction

      function void check_result(drive_result_type got);
         drive_result_type exp_r;
         checked++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
            return;
         end
         exp_r = pending.pop_front();
         if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected L=%0d R=%0d E=%0d, got L=%0d R=%0d E=%0d",
                  exp_r.left_duty, exp_r.right_duty, exp_r.line_error,
                  got.left_duty, got.right_duty, got.line_error);
         end
      endfunction
   endclass

   logic clock, reset;
   lpd_req_if req ();
   lpd_rsp_if rsp ();
   lpd_csr_if csr ();
   drive_scoreboard board;
   int idle_cycles, sent, phases;
   bit stim_done;

   line_position_pid_drive_unit u_dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source), .csr(csr.sink)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      board = new();
      board.reset_state();
   end

   function int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 45) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_request(logic [11:0] a, logic [11:0] b, logic [11:0] c,
                               logic [11:0] d);
      logic [11:0] s[4];
      int g;
      g = gap_len();
      if (g > 0) begin
         req.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      s = '{a, b, c, d};
      req.valid <= 1'b1;
      req.sample_a <= a; req.sample_b <= b; req.sample_c <= c; req.sample_d <= d;
      do @(posedge clock); while (!req.ready);
      board.note_request(s);
      sent++;
   endtask

   task automatic write_reg(logic [2:0] idx, logic [11:0] value);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data <= value;
      do @(posedge clock); while (!csr.ready);
      board.write_reg(idx, value);
      csr.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   function logic [11:0] rand_sample();
      int p;
      p = $urandom_range(0, 9);
      if (p < 2) return 12'($urandom_range(0, 1700));
      if (p < 3) return 12'($urandom_range(4000, 4095));
      if (p < 4) return 12'($urandom_range(1690, 1710));
      return 12'($urandom_range(1700, 4000));
   endfunction

   task automatic random_phase(int n);
      for (int i = 0; i < n; i++)
         send_request(rand_sample(), rand_sample(), rand_sample(), rand_sample());
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(0, 9) < 7) || stim_done;
         if (rsp.valid && rsp.ready)
            board.check_result('{rsp.left_duty, rsp.right_duty, rsp.line_error});
      end
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)
          || (csr.valid && csr.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 5000) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      stim_done = 0;
      sent = 0;
      idle_cycles = 0;
      req.valid = 1'b0;
      req.sample_a = '0; req.sample_b = '0; req.sample_c = '0; req.sample_d = '0;
      csr.valid = 1'b0; csr.index = '0; csr.data = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, lost line in both directions, zero sum, each sensor.
      send_request(12'd0, 12'd0, 12'd0, 12'd0);
      send_request(12'd4095, 12'd4095, 12'd4095, 12'd4095);
      send_request(12'd4095, 12'd0, 12'd0, 12'd0);
      send_request(12'd0, 12'd0, 12'd0, 12'd0);
      send_request(12'd0, 12'd0, 12'd0, 12'd4095);
      send_request(12'd0, 12'd0, 12'd0, 12'd0);
      send_request(12'd0, 12'd4095, 12'd0, 12'd0);
      send_request(12'd0, 12'd0, 12'd4095, 12'd0);
      send_request(12'd1700, 12'd1701, 12'd1724, 12'd4000);
      send_request(12'd2620, 12'd2621, 12'd2622, 12'd1700);
      send_request(12'hAAA, 12'h555, 12'hFFF, 12'h800);
      send_request(12'h555, 12'hAAA, 12'h7FF, 12'hFFF);
      drain();

      write_reg(RegGainI, 12'd4095);
      write_reg(RegGainP, 12'd4095);
      write_reg(RegGainD, 12'd4095);
      write_reg(RegDarkThr, 12'd0);
      write_reg(RegBaseDuty, 12'd100);
      write_reg(RegFloor, 12'd0);
      write_reg(RegCeiling, 12'd100);
      send_request(12'd4095, 12'd0, 12'd0, 12'd0);
      send_request(12'd4095, 12'd0, 12'd0, 12'd0);
      send_request(12'd0, 12'd0, 12'd0, 12'd4095);
      send_request(12'd1701, 12'd0, 12'd0, 12'd0);
      random_phase(150);
      drain();

      // Floor above ceiling, and the dark threshold and base duty at their largest values.
      write_reg(RegFloor, 12'd90);
      write_reg(RegCeiling, 12'd40);
      write_reg(RegDarkThr, 12'd1023);
      write_reg(RegBaseDuty, 12'd127);
      random_phase(100);
      drain();

      for (phases = 0; phases < 4; phases++) begin
         write_reg(RegGainP, 12'($urandom_range(0, 4095)));
         write_reg(RegGainI, 12'($urandom_range(0, 600)));
         write_reg(RegGainD, 12'($urandom_range(0, 4095)));
         write_reg(RegDarkThr, 12'($urandom_range(0, 1000)));
         write_reg(RegBaseDuty, 12'($urandom_range(0, 127)));
         write_reg(RegFloor, 12'($urandom_range(0, 80)));
         write_reg(RegCeiling, 12'($urandom_range(60, 127)));
         random_phase(140);
         drain();
      end

      write_reg(RegGainP, 12'd0);
      write_reg(RegGainI, 12'd0);
      write_reg(RegGainD, 12'd0);
      write_reg(RegFloor, 12'd127);
      write_reg(RegCeiling, 12'd127);
      random_phase(20);
      stim_done = 1;
      drain();
      repeat (40) @(posedge clock);

      $display("Sent %0d sensor sets over several register settings, %0d results checked.",
         sent, board.checked);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches, %0d results outstanding", board.mismatches,
            board.pending.size());
         $display("FAIL");
      end
      $finish;
   end
endmodule
